[rtl/pes_pkg.sv]
package pes_pkg;

    localparam int MAX_TASKS = 3;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [2:0] {
        ACT_IDLE     = 3'd0,
        ACT_DISCARD  = 3'd1,
        ACT_SERVE    = 3'd2,
        ACT_EXCHANGE = 3'd3,
        ACT_RUN      = 3'd4
    } t_action;

    localparam logic [CFG_IDX_W-1:0] REG_SERVER_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_PERIOD   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TASK0_PERIOD    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TASK0_WCET      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TASK1_PERIOD    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TASK1_WCET      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TASK2_PERIOD    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TASK2_WCET      = 8'd7;

    typedef struct packed {
        logic [7:0]                  server_capacity;
        logic [15:0]                 server_period;
        logic [MAX_TASKS-1:0][15:0]  task_period;
        logic [MAX_TASKS-1:0][7:0]   task_wcet;
    } t_cfg;

    typedef struct packed {
        logic       arrives;
        logic [7:0] tag;
        logic [7:0] exec;
    } t_job;

    typedef struct packed {
        logic       pending;
        logic       overflow;
        logic       done;
        logic [7:0] done_tag;
    } t_qstat;

    typedef struct packed {
        t_action    action;
        logic [1:0] spent_level;
        logic [1:0] task_run;
        logic [1:0] parked_level;
        logic       job_done;
        logic [7:0] done_tag;
        logic [2:0] miss_mask;
        logic       queue_overflow;
    } t_result;

    function automatic logic [7:0] sat8_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

[rtl/pes_cfg_if.sv]
interface pes_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [15:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/pes_job_if.sv]
interface pes_job_if;
    logic       valid;
    logic       ready;
    logic       job_arrives;
    logic [7:0] job_tag;
    logic [7:0] job_exec;

    modport source(output valid, job_arrives, job_tag, job_exec, input ready);
    modport sink(input valid, job_arrives, job_tag, job_exec, output ready);
endinterface

[rtl/pes_res_if.sv]
interface pes_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [1:0] spent_level;
    logic [1:0] task_run;
    logic [1:0] parked_level;
    logic       job_done;
    logic [7:0] done_tag;
    logic [2:0] miss_mask;
    logic       queue_overflow;

    modport source(output valid, action, spent_level, task_run, parked_level, job_done,
                   done_tag, miss_mask, queue_overflow, input ready);
    modport sink(input valid, action, spent_level, task_run, parked_level, job_done,
                 done_tag, miss_mask, queue_overflow, output ready);
endinterface

[rtl/pes_cfg_regs.sv]
module pes_cfg_regs import pes_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pes_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.server_capacity <= 8'd1;
            r_cfg.server_period   <= 16'd5;
            r_cfg.task_period[0]  <= 16'd10;
            r_cfg.task_wcet[0]    <= 8'd2;
            r_cfg.task_period[1]  <= 16'd20;
            r_cfg.task_wcet[1]    <= 8'd6;
            r_cfg.task_period[2]  <= 16'd1;
            r_cfg.task_wcet[2]    <= 8'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SERVER_CAPACITY: r_cfg.server_capacity <= i_cfg.data[7:0];
                REG_SERVER_PERIOD:   r_cfg.server_period   <= i_cfg.data;
                REG_TASK0_PERIOD:    r_cfg.task_period[0]  <= i_cfg.data;
                REG_TASK0_WCET:      r_cfg.task_wcet[0]    <= i_cfg.data[7:0];
                REG_TASK1_PERIOD:    r_cfg.task_period[1]  <= i_cfg.data;
                REG_TASK1_WCET:      r_cfg.task_wcet[1]    <= i_cfg.data[7:0];
                REG_TASK2_PERIOD:    r_cfg.task_period[2]  <= i_cfg.data;
                REG_TASK2_WCET:      r_cfg.task_wcet[2]    <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

endmodule

[rtl/pes_job_queue.sv]
module pes_job_queue import pes_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_step,
    input  t_job   i_job,
    input  logic   i_serve,
    output t_qstat o_qstat
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // entry layout: remaining units in [15:8], tag in [7:0]
    logic [15:0]   r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [15:0]   r_head_ent;
    logic [15:0]   r_second;   // registered read of the entry behind the head

    logic          full, enq, done, has_next;
    logic [7:0]    exec_fix;
    logic [15:0]   in_ent, cur_ent, n_head_ent;
    logic [AW-1:0] wslot, n_head, raddr;
    logic [CW-1:0] n_count;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            return AW'(s - (AW+1)'(QUEUE_DEPTH));
        end
        return AW'(s);
    endfunction

    always_comb begin
        full     = (r_count == CW'(QUEUE_DEPTH));
        enq      = i_job.arrives && !full;
        exec_fix = (i_job.exec == 8'd0) ? 8'd1 : i_job.exec;
        in_ent   = {exec_fix, i_job.tag};
        cur_ent  = (r_count == '0) ? in_ent : r_head_ent;
        done     = i_serve && (cur_ent[15:8] <= 8'd1);
        has_next = (r_count >= CW'(2)) || ((r_count == CW'(1)) && enq);
        wslot    = wrap({1'b0, r_head} + (AW+1)'(r_count));

        n_head     = r_head;
        n_head_ent = r_head_ent;
        n_count    = r_count;
        if (i_step) begin
            n_count = r_count + CW'(enq) - CW'(done);
            if (done) begin
                n_head = wrap({1'b0, r_head} + (AW+1)'(1));
                if (r_count >= CW'(2)) begin
                    n_head_ent = r_second;
                end else begin
                    n_head_ent = in_ent;
                end
            end else if (i_serve) begin
                n_head_ent = {cur_ent[15:8] - 8'd1, cur_ent[7:0]};
            end else if (r_count == '0) begin
                n_head_ent = in_ent;
            end
        end
        raddr = wrap({1'b0, n_head} + (AW+1)'(1));

        o_qstat.pending  = (r_count != '0) || enq;
        o_qstat.overflow = i_job.arrives && full;
        o_qstat.done     = done;
        o_qstat.done_tag = done ? cur_ent[7:0] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && enq) begin
            r_mem[wslot] <= in_ent;
        end
        if (i_step && enq && (wslot == raddr)) begin
            r_second <= in_ent;
        end else begin
            r_second <= r_mem[raddr];
        end
        if (!done || has_next) begin
            r_head_ent <= n_head_ent;
        end
    end

endmodule

[rtl/pes_core.sv]
module pes_core import pes_pkg::*; #(
    parameter int N_TASKS = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_cfg    i_cfg,
    input  t_qstat  i_qstat,
    output logic    o_serve,
    output t_result o_result
);

    localparam int NLEV = N_TASKS + 1;
    localparam int LW   = $clog2(NLEV);
    localparam int TW   = (N_TASKS > 1) ? $clog2(N_TASKS) : 1;

    logic [15:0] r_rel_cnt  [N_TASKS];
    logic [7:0]  r_task_rem [N_TASKS];
    logic [15:0] r_srv_cnt;
    logic [7:0]  r_budget   [NLEV];

    logic [15:0] n_rel_cnt  [N_TASKS];
    logic [7:0]  rem_rel    [N_TASKS];
    logic [7:0]  n_task_rem [N_TASKS];
    logic [15:0] n_srv_cnt;
    logic [7:0]  budget_rep [NLEV];
    logic [7:0]  n_budget   [NLEV];

    logic [2:0]    miss;
    logic          have_p, have_b;
    logic [TW-1:0] pidx;
    logic [LW-1:0] bidx, plevel;
    logic          serve, exch, run, disc;
    t_action       action;

    always_comb begin
        miss = '0;
        for (int i = 0; i < N_TASKS; i++) begin
            if (r_rel_cnt[i] == 16'd0) begin
                miss[i]      = (r_task_rem[i] != 8'd0);
                rem_rel[i]   = sat8_add(r_task_rem[i], i_cfg.task_wcet[i]);
                // a zero period acts as one
                n_rel_cnt[i] = (i_cfg.task_period[i] == 16'd0) ?
                               16'd0 : i_cfg.task_period[i] - 16'd1;
            end else begin
                rem_rel[i]   = r_task_rem[i];
                n_rel_cnt[i] = r_rel_cnt[i] - 16'd1;
            end
        end

        for (int l = 0; l < NLEV; l++) begin
            budget_rep[l] = r_budget[l];
        end
        if (r_srv_cnt == 16'd0) begin
            budget_rep[0] = sat8_add(r_budget[0], i_cfg.server_capacity);
            n_srv_cnt = (i_cfg.server_period == 16'd0) ? 16'd0 : i_cfg.server_period - 16'd1;
        end else begin
            n_srv_cnt = r_srv_cnt - 16'd1;
        end

        have_p = 1'b0;
        pidx   = '0;
        for (int i = N_TASKS - 1; i >= 0; i--) begin
            if (rem_rel[i] != 8'd0) begin
                have_p = 1'b1;
                pidx   = TW'(i);
            end
        end
        have_b = 1'b0;
        bidx   = '0;
        for (int l = NLEV - 1; l >= 0; l--) begin
            if (budget_rep[l] != 8'd0) begin
                have_b = 1'b1;
                bidx   = LW'(l);
            end
        end
        plevel = LW'(pidx) + LW'(1);

        serve = i_qstat.pending && have_b && (!have_p || (bidx <= plevel));
        exch  = !i_qstat.pending && have_p && have_b && (bidx < plevel);
        run   = !serve && !exch && have_p;
        disc  = !serve && !exch && !have_p && have_b;

        for (int l = 0; l < NLEV; l++) begin
            n_budget[l] = budget_rep[l];
        end
        if (serve || exch || disc) begin
            n_budget[bidx] = budget_rep[bidx] - 8'd1;
        end
        if (exch) begin
            // a unit parked onto a full level is lost
            n_budget[plevel] = sat8_add(budget_rep[plevel], 8'd1);
        end

        for (int i = 0; i < N_TASKS; i++) begin
            n_task_rem[i] = rem_rel[i];
        end
        if (exch || run) begin
            n_task_rem[pidx] = rem_rel[pidx] - 8'd1;
        end

        if (serve) begin
            action = ACT_SERVE;
        end else if (exch) begin
            action = ACT_EXCHANGE;
        end else if (run) begin
            action = ACT_RUN;
        end else if (disc) begin
            action = ACT_DISCARD;
        end else begin
            action = ACT_IDLE;
        end

        o_serve                 = serve;
        o_result.action         = action;
        o_result.spent_level    = (serve || exch || disc) ? 2'(bidx) : 2'd0;
        o_result.task_run       = (exch || run) ? 2'(pidx) : 2'd0;
        o_result.parked_level   = exch ? 2'(plevel) : 2'd0;
        o_result.job_done       = i_qstat.done;
        o_result.done_tag       = i_qstat.done_tag;
        o_result.miss_mask      = miss;
        o_result.queue_overflow = i_qstat.overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_TASKS; i++) begin
                r_rel_cnt[i]  <= 16'd0;
                r_task_rem[i] <= 8'd0;
            end
            for (int l = 0; l < NLEV; l++) begin
                r_budget[l] <= 8'd0;
            end
            r_srv_cnt <= 16'd0;
        end else if (i_step) begin
            for (int i = 0; i < N_TASKS; i++) begin
                r_rel_cnt[i]  <= n_rel_cnt[i];
                r_task_rem[i] <= n_task_rem[i];
            end
            for (int l = 0; l < NLEV; l++) begin
                r_budget[l] <= n_budget[l];
            end
            r_srv_cnt <= n_srv_cnt;
        end
    end

endmodule

[rtl/priority_exchange_scheduler.sv]
// Priority Exchange server scheduler. Each request on the job channel is one time
// unit (tick): it releases due periodic tasks, queues an optional aperiodic job,
// replenishes the level-0 server budget and makes one scheduling choice, returned
// as exactly one result per tick on the result channel. A tick enters the input
// register, is evaluated by combinational logic and lands in the result register.
// One tick is taken every cycle while results are taken; a tick waits in the
// input register as long as a result waits in the result register. Configuration
// writes are always ready and belong to idle periods. The aperiodic queue holds
// QUEUE_DEPTH jobs in a memory; the head job and the one behind it are kept in
// registers so the single read port keeps up with one completion per tick.
module priority_exchange_scheduler import pes_pkg::*; #(
    parameter int N_TASKS     = 3,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pes_cfg_if.sink   i_cfg,
    pes_job_if.sink   i_job,
    pes_res_if.source o_res
);

    t_cfg    cfg;
    t_qstat  qstat;
    t_result result;
    logic    serve, step;

    logic    r_in_v;
    t_job    r_in;
    logic    r_out_v;
    t_result r_out;

    assign step        = r_in_v && (!r_out_v || o_res.ready);
    assign i_job.ready = !r_in_v || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_job.ready) begin
                r_in_v <= i_job.valid;
            end
            if (step) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.valid && i_job.ready) begin
            r_in.arrives <= i_job.job_arrives;
            r_in.tag     <= i_job.job_tag;
            r_in.exec    <= i_job.job_exec;
        end
        if (step) begin
            r_out <= result;
        end
    end

    pes_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pes_job_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_job   (r_in),
        .i_serve (serve),
        .o_qstat (qstat)
    );

    pes_core #(.N_TASKS(N_TASKS)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (cfg),
        .i_qstat  (qstat),
        .o_serve  (serve),
        .o_result (result)
    );

    assign o_res.valid          = r_out_v;
    assign o_res.action         = r_out.action;
    assign o_res.spent_level    = r_out.spent_level;
    assign o_res.task_run       = r_out.task_run;
    assign o_res.parked_level   = r_out.parked_level;
    assign o_res.job_done       = r_out.job_done;
    assign o_res.done_tag       = r_out.done_tag;
    assign o_res.miss_mask      = r_out.miss_mask;
    assign o_res.queue_overflow = r_out.queue_overflow;

endmodule

[test/priority_exchange_scheduler_checker.sv]
module priority_exchange_scheduler_checker import pes_pkg::*; #(
    parameter int N_TASKS     = 3,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pes_cfg_if   i_cfg,
    pes_job_if   i_ticks,
    pes_res_if   i_res,
    output int   o_error_count,
    output int   o_decisions_owed
);

    // scheduler settings as last written
    logic [7:0]  srv_capacity;
    logic [15:0] srv_period;
    logic [15:0] task_period [MAX_TASKS];
    logic [7:0]  task_wcet   [MAX_TASKS];

    // scheduler state
    logic [15:0] release_left [MAX_TASKS];
    logic [15:0] replenish_left;
    logic [7:0]  work_left    [MAX_TASKS];
    logic [7:0]  budget       [MAX_TASKS+1];
    logic [15:0] jobq         [QUEUE_DEPTH];
    int unsigned q_head;
    int unsigned q_count;

    t_result expected_decisions[$];
    int      errors;
    int      decisions_seen;

    function automatic logic [7:0] sat_sum8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > 9'd255) ? 8'd255 : s[7:0];
    endfunction

    // One time unit: releases, arrival, replenishment, then one scheduling choice.
    function automatic t_result schedule_tick(input logic arrives, input logic [7:0] tag,
                                              input logic [7:0] exec_units);
        t_result    r;
        int         ready_lvl;
        int         budget_lvl;
        logic [7:0] units;
        logic [15:0] head_entry;
        r = '0;
        r.action = ACT_IDLE;
        ready_lvl = -1;
        budget_lvl = -1;

        for (int i = 0; i < N_TASKS; i++) begin
            if (release_left[i] == 16'd0) begin
                if (work_left[i] != 8'd0) r.miss_mask[i] = 1'b1;
                work_left[i] = sat_sum8(work_left[i], task_wcet[i]);
                release_left[i] = (task_period[i] == 16'd0) ? 16'd0 : task_period[i] - 16'd1;
            end else begin
                release_left[i] = release_left[i] - 16'd1;
            end
        end

        if (arrives) begin
            if (q_count >= QUEUE_DEPTH) begin
                r.queue_overflow = 1'b1;
            end else begin
                units = (exec_units == 8'd0) ? 8'd1 : exec_units;
                jobq[(q_head + q_count) % QUEUE_DEPTH] = {units, tag};
                q_count++;
            end
        end

        if (replenish_left == 16'd0) begin
            budget[0] = sat_sum8(budget[0], srv_capacity);
            replenish_left = (srv_period == 16'd0) ? 16'd0 : srv_period - 16'd1;
        end else begin
            replenish_left = replenish_left - 16'd1;
        end

        for (int i = N_TASKS - 1; i >= 0; i--)
            if (work_left[i] != 8'd0) ready_lvl = i + 1;
        for (int i = N_TASKS; i >= 0; i--)
            if (budget[i] != 8'd0) budget_lvl = i;

        if (q_count > 0 && budget_lvl >= 0 && (ready_lvl < 0 || budget_lvl <= ready_lvl)) begin
            head_entry = jobq[q_head];
            units = head_entry[15:8];
            budget[budget_lvl] = budget[budget_lvl] - 8'd1;
            units = (units > 8'd0) ? units - 8'd1 : 8'd0;
            r.action = ACT_SERVE;
            r.spent_level = budget_lvl[1:0];
            if (units == 8'd0) begin
                r.job_done = 1'b1;
                r.done_tag = head_entry[7:0];
                q_head = (q_head + 1) % QUEUE_DEPTH;
                q_count--;
            end else begin
                jobq[q_head] = {units, head_entry[7:0]};
            end
        end else if (q_count == 0 && ready_lvl >= 0 && budget_lvl >= 0
                     && budget_lvl < ready_lvl) begin
            // budget is traded down to the running task's level
            budget[budget_lvl] = budget[budget_lvl] - 8'd1;
            budget[ready_lvl] = sat_sum8(budget[ready_lvl], 8'd1);
            work_left[ready_lvl-1] = work_left[ready_lvl-1] - 8'd1;
            r.action = ACT_EXCHANGE;
            r.spent_level = budget_lvl[1:0];
            r.task_run = 2'(ready_lvl - 1);
            r.parked_level = ready_lvl[1:0];
        end else if (ready_lvl >= 0) begin
            work_left[ready_lvl-1] = work_left[ready_lvl-1] - 8'd1;
            r.action = ACT_RUN;
            r.task_run = 2'(ready_lvl - 1);
        end else if (budget_lvl >= 0) begin
            budget[budget_lvl] = budget[budget_lvl] - 8'd1;
            r.action = ACT_DISCARD;
            r.spent_level = budget_lvl[1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            srv_capacity = 8'd1;
            srv_period = 16'd5;
            task_period[0] = 16'd10;
            task_wcet[0] = 8'd2;
            task_period[1] = 16'd20;
            task_wcet[1] = 8'd6;
            task_period[2] = 16'd1;
            task_wcet[2] = 8'd0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                release_left[i] = 16'd0;
                work_left[i] = 8'd0;
            end
            for (int i = 0; i <= MAX_TASKS; i++) budget[i] = 8'd0;
            replenish_left = 16'd0;
            q_head = 0;
            q_count = 0;
            expected_decisions.delete();
            errors = 0;
            decisions_seen = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.action = t_action'(i_res.action);
                got.spent_level = i_res.spent_level;
                got.task_run = i_res.task_run;
                got.parked_level = i_res.parked_level;
                got.job_done = i_res.job_done;
                got.done_tag = i_res.done_tag;
                got.miss_mask = i_res.miss_mask;
                got.queue_overflow = i_res.queue_overflow;
                if (expected_decisions.size() == 0) begin
                    if (errors < 10)
                        $display("decision %0d arrived with no tick outstanding", decisions_seen);
                    errors++;
                end else begin
                    want = expected_decisions.pop_front();
                    if (got !== want) begin
                        if (errors < 10) begin
                            $display("decision %0d mismatch: expected act=%0d blev=%0d task=%0d",
                                     decisions_seen, want.action, want.spent_level,
                                     want.task_run);
                            $display("  park=%0d done=%0b tag=%02h miss=%03b ovf=%0b",
                                     want.parked_level, want.job_done, want.done_tag,
                                     want.miss_mask, want.queue_overflow);
                            $display("  got act=%0d blev=%0d task=%0d park=%0d done=%0b",
                                     got.action, got.spent_level, got.task_run,
                                     got.parked_level, got.job_done);
                            $display("  tag=%02h miss=%03b ovf=%0b",
                                     got.done_tag, got.miss_mask, got.queue_overflow);
                        end
                        errors++;
                    end
                end
                decisions_seen++;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_SERVER_CAPACITY: srv_capacity = i_cfg.data[7:0];
                    REG_SERVER_PERIOD:   srv_period = i_cfg.data;
                    REG_TASK0_PERIOD:    task_period[0] = i_cfg.data;
                    REG_TASK0_WCET:      task_wcet[0] = i_cfg.data[7:0];
                    REG_TASK1_PERIOD:    task_period[1] = i_cfg.data;
                    REG_TASK1_WCET:      task_wcet[1] = i_cfg.data[7:0];
                    REG_TASK2_PERIOD:    task_period[2] = i_cfg.data;
                    REG_TASK2_WCET:      task_wcet[2] = i_cfg.data[7:0];
                    default: ;
                endcase
            end
            if (i_ticks.valid && i_ticks.ready)
                expected_decisions.push_back(schedule_tick(i_ticks.job_arrives,
                                                           i_ticks.job_tag,
                                                           i_ticks.job_exec));
        end
        o_error_count <= errors;
        o_decisions_owed <= expected_decisions.size();
    end

endmodule

[test/priority_exchange_scheduler_tb.sv]
module priority_exchange_scheduler_tb;
    import pes_pkg::*;

    localparam int N_TASKS     = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_TICKS = 155;
    localparam int HOLD_EVERY  = 600;
    localparam int HOLD_CYCLES = 64;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    typedef enum {SET_LOW, SET_HIGH, SET_MIX} t_setting_mode;

    logic clk = 1'b0;
    logic rst_n;
    int   burst_left;
    int   error_count;
    int   decisions_owed;
    int   wd_cycles;

    pes_cfg_if cfg_bus();
    pes_job_if tick_bus();
    pes_res_if sched_res();

    priority_exchange_scheduler #(
        .N_TASKS    (N_TASKS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cfg  (cfg_bus),
        .i_job  (tick_bus),
        .o_res  (sched_res)
    );

    priority_exchange_scheduler_checker #(
        .N_TASKS    (N_TASKS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) scoreboard (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg           (cfg_bus),
        .i_ticks         (tick_bus),
        .i_res           (sched_res),
        .o_error_count   (error_count),
        .o_decisions_owed(decisions_owed)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic write_setting(input logic [7:0] idx, input logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering ticks and wait for every decision to come back
    task automatic settle();
        tick_bus.valid <= 1'b0;
        do @(posedge clk); while (decisions_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic issue_tick(input logic arrives, input logic [7:0] tag,
                              input logic [7:0] units);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        tick_bus.valid <= 1'b1;
        tick_bus.job_arrives <= arrives;
        tick_bus.job_tag <= tag;
        tick_bus.job_exec <= units;
        @(posedge clk);
        while (!tick_bus.ready) @(posedge clk);
    endtask

    function automatic logic [15:0] setting_value(input logic [7:0] idx,
                                                  input t_setting_mode mode);
        logic is_period;
        int   pick;
        is_period = !(idx == REG_SERVER_CAPACITY || idx == REG_TASK0_WCET
                      || idx == REG_TASK1_WCET || idx == REG_TASK2_WCET);
        pick = (mode == SET_LOW) ? 0 : (mode == SET_HIGH) ? 1 : $urandom_range(0, 9);
        if (pick == 0)
            return is_period ? 16'($urandom_range(0, 1)) : 16'd0;
        if (pick == 1)
            return is_period ? 16'hFFFF : 16'd255;
        if (idx == REG_SERVER_PERIOD)
            return 16'($urandom_range(1, 8));
        if (is_period)
            return 16'($urandom_range(2, 24));
        if (idx == REG_SERVER_CAPACITY)
            return 16'($urandom_range(1, 4));
        return 16'($urandom_range(0, 4));
    endfunction

    task automatic run_phase(input t_setting_mode mode);
        int         arrive_pct;
        logic [7:0] units;
        settle();
        for (int r = 0; r < 8; r++)
            write_setting(8'(r), setting_value(8'(r), mode));
        case ($urandom_range(0, 2))
            0:       arrive_pct = 15;
            1:       arrive_pct = 50;
            default: arrive_pct = 90;
        endcase
        for (int k = 0; k < PHASE_TICKS; k++) begin
            if (k == 60) settle();
            units = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 6));
            issue_tick($urandom_range(0, 99) < arrive_pct, 8'($urandom), units);
        end
    endtask

    // result side: random ready patterns plus a periodic long hold-off
    initial begin
        int since_hold;
        int stretch;
        int pattern;
        sched_res.ready <= 1'b0;
        since_hold = 0;
        forever begin
            stretch = $urandom_range(1, 40);
            pattern = $urandom_range(0, 2);
            for (int k = 0; k < stretch; k++) begin
                @(posedge clk);
                since_hold++;
                if (since_hold >= HOLD_EVERY) begin
                    since_hold = 0;
                    sched_res.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end else if (pattern == 0) begin
                    sched_res.ready <= 1'b1;
                end else if (pattern == 1) begin
                    sched_res.ready <= ($urandom_range(0, 3) != 0);
                end else begin
                    sched_res.ready <= ($urandom_range(0, 3) == 0);
                end
            end
        end
    end

    initial begin
        wd_cycles = 0;
        while (wd_cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            wd_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        rst_n <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data <= '0;
        tick_bus.valid <= 1'b0;
        tick_bus.job_arrives <= 1'b0;
        tick_bus.job_tag <= 8'd0;
        tick_bus.job_exec <= 8'd0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-up settings: field extremes, zero-length job, then overrun the queue
        repeat (3) issue_tick(1'b0, 8'hFF, 8'hFF);
        issue_tick(1'b1, 8'h00, 8'd1);
        issue_tick(1'b1, 8'hFF, 8'd0);
        issue_tick(1'b1, 8'hA5, 8'd255);
        for (int k = 0; k < 9; k++) issue_tick(1'b1, 8'h5A + 8'(k), 8'd2);
        settle();

        // zero periods, saturating budgets and work, writes to unused indexes
        write_setting(REG_SERVER_CAPACITY, 16'd255);
        write_setting(REG_SERVER_PERIOD, 16'd0);
        write_setting(REG_TASK0_PERIOD, 16'hFFFF);
        write_setting(REG_TASK0_WCET, 16'd255);
        write_setting(REG_TASK1_PERIOD, 16'd1);
        write_setting(REG_TASK1_WCET, 16'd0);
        write_setting(REG_TASK2_PERIOD, 16'd0);
        write_setting(REG_TASK2_WCET, 16'hFFFF);
        write_setting(REG_UNUSED_LOW, 16'h0001);
        write_setting(REG_UNUSED_HIGH, 16'hFFFF);
        for (int k = 0; k < 8; k++)
            issue_tick(k[0], k[0] ? 8'h3C : 8'hC3, 8'd1);

        run_phase(SET_MIX);
        run_phase(SET_LOW);
        run_phase(SET_MIX);
        run_phase(SET_HIGH);
        run_phase(SET_MIX);
        run_phase(SET_MIX);
        run_phase(SET_LOW);
        run_phase(SET_MIX);

        settle();
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
